### sv/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam int LEN_W = 63;

    // 7-bit length codes that announce an extended length field
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic             is_header;
        logic             fin;
        logic [2:0]       rsv;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] length;
        logic [7:0]       payload;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

### sv/wsd_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_parse (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    output logic                  res_valid,
    output wsd_pkg::result_t      res
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASKKEY = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam int LW = wsd_pkg::LEN_W;

    logic [2:0]    phase_reg, phase_next;
    logic [3:0]    count_reg, count_next;
    logic          ext_long_reg, ext_long_next;
    logic          fin_reg, fin_next;
    logic [2:0]    rsv_reg, rsv_next;
    logic [3:0]    opcode_reg, opcode_next;
    logic [3:0]    prior_reg, prior_next;
    logic          masked_reg, masked_next;
    logic [LW-1:0] length_reg, length_next;
    logic [31:0]   key_reg, key_next;
    logic [LW-1:0] done_reg, done_next;

    logic [3:0]    count_inc;
    logic [LW-1:0] done_inc;
    logic [6:0]    len7;
    logic [7:0]    key_byte;
    logic          do_finish;
    logic          pay_word;
    logic          pay_last;

    assign count_inc = count_reg + 4'd1;
    assign done_inc  = done_reg + {{(LW-1){1'b0}}, 1'b1};
    assign len7      = rx_byte[6:0];

    always_comb
    begin
        case (done_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        ext_long_next = ext_long_reg;
        fin_next      = fin_reg;
        rsv_next      = rsv_reg;
        opcode_next   = opcode_reg;
        prior_next    = prior_reg;
        masked_next   = masked_reg;
        length_next   = length_reg;
        key_next      = key_reg;
        done_next     = done_reg;
        do_finish     = 1'b0;
        pay_word      = 1'b0;
        pay_last      = 1'b0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next = rx_byte[7];
                rsv_next = rx_byte[6:4];
                if (rx_byte[3:0] != 4'd0)
                begin
                    opcode_next = rx_byte[3:0];
                    prior_next  = rx_byte[3:0];
                end
                else
                begin
                    // continuation reports the last nonzero opcode
                    opcode_next = prior_reg;
                end
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked_next = rx_byte[7];
                count_next  = 4'd0;
                if (len7 == wsd_pkg::LEN7_EXT16 || len7 == wsd_pkg::LEN7_EXT64)
                begin
                    ext_long_next = (len7 == wsd_pkg::LEN7_EXT64);
                    length_next   = '0;
                    phase_next    = PH_EXTLEN;
                end
                else
                begin
                    length_next = {{(LW-7){1'b0}}, len7};
                    if (rx_byte[7])
                        phase_next = PH_MASKKEY;
                    else
                        do_finish = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                // big-endian shift; the top bit of a 64-bit length falls off
                length_next = {length_reg[LW-9:0], rx_byte};
                count_next  = count_inc;
                if (count_inc >= (ext_long_reg ? wsd_pkg::EXT64_BYTES
                                               : wsd_pkg::EXT16_BYTES))
                begin
                    count_next = 4'd0;
                    if (masked_reg)
                        phase_next = PH_MASKKEY;
                    else
                        do_finish = 1'b1;
                end
            end
            PH_MASKKEY:
            begin
                key_next   = {key_reg[23:0], rx_byte};
                count_next = count_inc;
                if (count_inc >= wsd_pkg::KEY_BYTES)
                begin
                    count_next = 4'd0;
                    do_finish  = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                pay_word  = 1'b1;
                done_next = done_inc;
                pay_last  = (done_inc >= length_reg);
                if (pay_last)
                    phase_next = PH_HDR0;
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        if (do_finish)
        begin
            done_next  = '0;
            phase_next = (length_next == '0) ? PH_HDR0 : PH_PAYLOAD;
        end
    end

    assign res_valid = accept & (do_finish | pay_word);

    always_comb
    begin
        res.is_header = do_finish;
        res.fin       = fin_next;
        res.rsv       = rsv_next;
        res.opcode    = opcode_next;
        res.masked    = masked_next;
        res.length    = length_next;
        res.payload   = do_finish ? 8'd0 : (rx_byte ^ (masked_reg ? key_byte : 8'd0));
        res.last      = do_finish ? (length_next == '0) : pay_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            count_reg    <= 4'd0;
            ext_long_reg <= 1'b0;
            fin_reg      <= 1'b0;
            rsv_reg      <= 3'd0;
            opcode_reg   <= 4'd0;
            prior_reg    <= 4'd0;
            masked_reg   <= 1'b0;
            length_reg   <= '0;
            key_reg      <= 32'd0;
            done_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            ext_long_reg <= ext_long_next;
            fin_reg      <= fin_next;
            rsv_reg      <= rsv_next;
            opcode_reg   <= opcode_next;
            prior_reg    <= prior_next;
            masked_reg   <= masked_next;
            length_reg   <= length_next;
            key_reg      <= key_next;
            done_reg     <= done_next;
        end
    end

endmodule

`default_nettype wire

### sv/wsd_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

// Output register plus one skid entry; input side stalls only when the skid is full.
module wsd_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              new_valid,
    input  wire wsd_pkg::result_t  new_res,
    input  wire logic              out_stall,
    output logic                   full,
    output logic                   out_valid,
    output wsd_pkg::result_t       out_res
);

    logic             out_valid_reg;
    wsd_pkg::result_t out_res_reg;
    logic             skid_valid_reg;
    wsd_pkg::result_t skid_res_reg;
    logic             out_free;

    assign out_free  = ~out_valid_reg | ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | new_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (new_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : new_res;
        end
        else if (new_valid)
        begin
            skid_res_reg <= new_res;
        end
    end

endmodule

`default_nettype wire

### sv/websocket_frame_deframer.sv
// WebSocket frame deframer.
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per word.
// Output channel: out_valid / out_stall carry one result word: a header summary
// when the last header byte arrives (is_header = 1), then one unmasked payload
// byte per payload input byte. The final word of a frame has last = 1; for a
// zero-length frame that is the header word itself.
// Header bytes other than the last produce no output word.
// Throughput: one byte per cycle while in_stall is low.
// Each result is registered in the output register, or in the skid entry.
// The parser state lives in the parse unit; results pass through an output
// register with one skid entry, so a byte is still taken in the cycle the
// output first stalls. in_stall rises only once the skid entry is occupied,
// i.e. after the receiver has stalled with two words pending.
// Reset (rst_n low, asynchronous) returns the parser to the first header byte,
// clears the remembered opcode and empties the output register and skid entry.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             is_header,
    output logic                             fin_flag,
    output logic [2:0]                       reserved_bits,
    output logic [3:0]                       frame_opcode,
    output logic                             masked_flag,
    output logic [wsd_pkg::LEN_W-1:0]        frame_length,
    output logic [7:0]                       payload_byte,
    output logic                             last
);

    logic             accept;
    logic             res_valid;
    wsd_pkg::result_t res;
    wsd_pkg::result_t out_res;
    logic             buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid & ~buf_full;

    wsd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .new_valid (res_valid),
        .new_res   (res),
        .out_stall (out_stall),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign is_header     = out_res.is_header;
    assign fin_flag      = out_res.fin;
    assign reserved_bits = out_res.rsv;
    assign frame_opcode  = out_res.opcode;
    assign masked_flag   = out_res.masked;
    assign frame_length  = out_res.length;
    assign payload_byte  = out_res.payload;
    assign last          = out_res.last;

endmodule

`default_nettype wire

### sv/wsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic                        is_header,
    input  wire logic                        fin_flag,
    input  wire logic [2:0]                  reserved_bits,
    input  wire logic [3:0]                  frame_opcode,
    input  wire logic                        masked_flag,
    input  wire logic [wsd_pkg::LEN_W-1:0]   frame_length,
    input  wire logic [7:0]                  payload_byte,
    input  wire logic                        last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
            && $stable(is_header) && $stable(last) && $stable(frame_length))
        else $error("output word changed while stalled");

    // input backpressure only with a word waiting at the output
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending output word");

    a_stall_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("in_stall rose without a stalled output");

    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_header |-> (last == (frame_length == '0)) && (payload_byte == 8'd0))
        else $error("header word last flag or payload inconsistent");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_header |-> frame_length != '0)
        else $error("payload word in a zero-length frame");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

`default_nettype wire

### bench/deframer_checker.sv
`timescale 1ns / 1ps

module deframer_checker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic [7:0]               rx_byte,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic                     is_header,
    input  wire logic                     fin_flag,
    input  wire logic [2:0]               reserved_bits,
    input  wire logic [3:0]               frame_opcode,
    input  wire logic                     masked_flag,
    input  wire logic [wsd_pkg::LEN_W-1:0] frame_length,
    input  wire logic [7:0]               payload_byte,
    input  wire logic                     last,
    output int                            mismatch_count,
    output int                            words_outstanding,
    output int                            words_checked
);

    localparam int LW = wsd_pkg::LEN_W;

    typedef enum logic [2:0] {
        HDR_FIRST,
        HDR_SECOND,
        EXT_LENGTH,
        KEY_FIELD,
        PAYLOAD_DATA
    } parse_step_t;

    parse_step_t       parse_step = HDR_FIRST;
    logic [3:0]        field_cnt = '0;
    logic [3:0]        ext_cnt = '0;
    logic              fin_r = 1'b0;
    logic [2:0]        rsv_r = '0;
    logic [3:0]        op_r = '0;
    logic [3:0]        last_nonzero_op = '0;
    logic              masked_r = 1'b0;
    logic [LW-1:0]     length_r = '0;
    logic [LW-1:0]     delivered = '0;
    logic [31:0]       key_r = '0;
    wsd_pkg::result_t  decoded_words[$];

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                    words_checked, name, got, want));
    endtask

    task automatic push_word(input logic hdr, input logic [7:0] data, input logic end_word);
        wsd_pkg::result_t w;
        w.is_header = hdr;
        w.fin       = fin_r;
        w.rsv       = rsv_r;
        w.opcode    = op_r;
        w.masked    = masked_r;
        w.length    = length_r;
        w.payload   = data;
        w.last      = end_word;
        decoded_words.push_back(w);
    endtask

    task automatic close_header();
        delivered = '0;
        push_word(1'b1, 8'h00, length_r == '0);
        parse_step = (length_r == '0) ? HDR_FIRST : PAYLOAD_DATA;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0] key_byte;
        case (parse_step)
            HDR_FIRST:
            begin
                fin_r = b[7];
                rsv_r = b[6:4];
                // continuation reports the last nonzero opcode (zero if none yet)
                if (b[3:0] != 4'h0)
                    last_nonzero_op = b[3:0];
                op_r = last_nonzero_op;
                parse_step = HDR_SECOND;
            end
            HDR_SECOND:
            begin
                masked_r = b[7];
                field_cnt = '0;
                if (b[6:0] == wsd_pkg::LEN7_EXT16 || b[6:0] == wsd_pkg::LEN7_EXT64)
                begin
                    ext_cnt = (b[6:0] == wsd_pkg::LEN7_EXT16) ? wsd_pkg::EXT16_BYTES
                                                              : wsd_pkg::EXT64_BYTES;
                    length_r = '0;
                    parse_step = EXT_LENGTH;
                end
                else
                begin
                    length_r = LW'(b[6:0]);
                    if (masked_r)
                        parse_step = KEY_FIELD;
                    else
                        close_header();
                end
            end
            EXT_LENGTH:
            begin
                // shifting through 63 bits drops the top bit of a 64-bit length
                length_r = {length_r[LW-9:0], b};
                field_cnt++;
                if (field_cnt == ext_cnt)
                begin
                    field_cnt = '0;
                    if (masked_r)
                        parse_step = KEY_FIELD;
                    else
                        close_header();
                end
            end
            KEY_FIELD:
            begin
                key_r = {key_r[23:0], b};
                field_cnt++;
                if (field_cnt == wsd_pkg::KEY_BYTES)
                begin
                    field_cnt = '0;
                    close_header();
                end
            end
            PAYLOAD_DATA:
            begin
                key_byte = masked_r ? 8'(key_r >> (24 - 8 * int'(delivered[1:0]))) : 8'h00;
                delivered = delivered + LW'(1);
                if (delivered >= length_r)
                begin
                    push_word(1'b0, b ^ key_byte, 1'b1);
                    parse_step = HDR_FIRST;
                end
                else
                    push_word(1'b0, b ^ key_byte, 1'b0);
            end
            default:
                parse_step = HDR_FIRST;
        endcase
    endtask

    task automatic compare_word();
        wsd_pkg::result_t seen;
        wsd_pkg::result_t want;
        seen = {is_header, fin_flag, reserved_bits, frame_opcode, masked_flag,
                frame_length, payload_byte, last};
        words_checked++;
        if (decoded_words.size() == 0)
        begin
            flag_mismatch($sformatf("word %0d arrived with none pending: %h",
                                    words_checked, seen));
            return;
        end
        want = decoded_words.pop_front();
        check_field("is_header", seen.is_header, want.is_header);
        check_field("fin_flag", seen.fin, want.fin);
        check_field("reserved_bits", seen.rsv, want.rsv);
        check_field("frame_opcode", seen.opcode, want.opcode);
        check_field("masked_flag", seen.masked, want.masked);
        check_field("frame_length", seen.length, want.length);
        check_field("payload_byte", seen.payload, want.payload);
        check_field("last", seen.last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_step = HDR_FIRST;
            field_cnt = '0;
            ext_cnt = '0;
            fin_r = 1'b0;
            rsv_r = '0;
            op_r = '0;
            last_nonzero_op = '0;
            masked_r = 1'b0;
            length_r = '0;
            delivered = '0;
            key_r = '0;
            decoded_words.delete();
            words_outstanding = 0;
        end
        else
        begin
            // a word leaving now always belongs to an earlier byte
            if (out_valid && !out_stall)
                compare_word();
            if (in_valid && !in_stall)
                parse_rx_byte(rx_byte);
            words_outstanding = decoded_words.size();
        end
    end

endmodule

### bench/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_BYTES  = 530;
    localparam int TAIL_CYCLES  = 8;

    typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic [7:0]                rx_byte = 8'h00;
    logic                      out_stall = 1'b0;
    logic                      in_stall;
    logic                      out_valid;
    logic                      is_header;
    logic                      fin_flag;
    logic [2:0]                reserved_bits;
    logic [3:0]                frame_opcode;
    logic                      masked_flag;
    logic [wsd_pkg::LEN_W-1:0] frame_length;
    logic [7:0]                payload_byte;
    logic                      last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_req = 1'b0;
    int cycle_count = 0;
    int frames_sent = 0;
    int bytes_sent = 0;
    int mismatch_count;
    int words_outstanding;
    int words_checked;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    websocket_frame_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_header     (is_header),
        .fin_flag      (fin_flag),
        .reserved_bits (reserved_bits),
        .frame_opcode  (frame_opcode),
        .masked_flag   (masked_flag),
        .frame_length  (frame_length),
        .payload_byte  (payload_byte),
        .last          (last)
    );

    deframer_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .is_header         (is_header),
        .fin_flag          (fin_flag),
        .reserved_bits     (reserved_bits),
        .frame_opcode      (frame_opcode),
        .masked_flag       (masked_flag),
        .frame_length      (frame_length),
        .payload_byte      (payload_byte),
        .last              (last),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding),
        .words_checked     (words_checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, words_outstanding);
            $display("websocket_frame_deframer_tb failed");
            $finish;
        end
    end

    // receiver side: random stalls, plus one long hold on request
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input len_form_t form,
                              input logic [63:0] len_field, input int body_len);
        send_byte({fin, rsv, op});
        case (form)
            LEN_SHORT:
                send_byte({masked, len_field[6:0]});
            LEN_EXT16:
            begin
                send_byte({masked, wsd_pkg::LEN7_EXT16});
                send_byte(len_field[15:8]);
                send_byte(len_field[7:0]);
            end
            default:
            begin
                send_byte({masked, wsd_pkg::LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len_field[8*i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 0; i < 4; i++)
                send_byte(8'($urandom));
        for (int i = 0; i < body_len; i++)
            send_byte(8'($urandom));
        frames_sent++;
    endtask

    task automatic send_random_frame();
        len_form_t   form;
        logic [63:0] len;
        logic [3:0]  op;
        int          pick;
        pick = $urandom_range(99);
        op = ($urandom_range(3) == 0) ? 4'h0 : 4'($urandom);
        if (pick < 70)
        begin
            form = LEN_SHORT;
            len = ($urandom_range(9) == 0) ? 64'($urandom_range(125))
                                           : 64'($urandom_range(12));
        end
        else if (pick < 85)
        begin
            form = LEN_EXT16;
            len = ($urandom_range(7) == 0) ? 64'($urandom_range(400))
                                           : 64'($urandom_range(20));
        end
        else
        begin
            form = LEN_EXT64;
            len = 64'($urandom_range(20));
        end
        send_frame(1'($urandom), 3'($urandom), op, 1'($urandom), form, len, int'(len));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // continuation before any real opcode, empty payload
        send_frame(1'b1, 3'd0, 4'h0, 1'b0, LEN_SHORT, 64'd0, 0);
        // all reserved bits set, highest opcode, masked
        send_frame(1'b0, 3'd7, 4'hF, 1'b1, LEN_SHORT, 64'd2, 2);
        // continuation inherits 0xF; 16-bit field carrying a short length
        send_frame(1'b0, 3'd0, 4'h0, 1'b0, LEN_EXT16, 64'd1, 1);
        // masked 64-bit field carrying a short length
        send_frame(1'b1, 3'd5, 4'h2, 1'b1, LEN_EXT64, 64'd1, 1);

        for (int phase = 0; phase < 3; phase++)
        begin
            int start;
            case (phase)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req <= 1'b1;
                end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_frame();
        end

        // 64-bit length with every bit set: top bit dropped, frame left open
        send_frame(1'b1, 3'd0, 4'h1, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 20);
        in_valid <= 1'b0;

        while (words_outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("sent %0d frames in %0d bytes over three stall mixes and one long output hold",
                 frames_sent, bytes_sent);
        $display("checked %0d output words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("websocket_frame_deframer_tb passed");
        else
            $display("websocket_frame_deframer_tb failed");
        $finish;
    end

endmodule
